/* sv/cafs_pkg.sv */
// Package for the contrast autofocus scan sequencer: phase codes, widths, constants.
// No dependencies.
package cafs_pkg;
  localparam int POS_BITS     = 10;
  localparam int MEASURE_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  typedef enum logic [3:0] {
    PH_TRANSIT, PH_START_IN, PH_SCAN_IN, PH_START_OUT, PH_SCAN_OUT,
    PH_START_FINE, PH_FINE, PH_SET_FOCUS, PH_LOCK, PH_START_DRIFT,
    PH_CONFIRM, PH_DRIFT_PEAK
  } phase_t;

  typedef enum logic [1:0] {
    REG_MAX_POS = 2'd0, REG_MIN_POS = 2'd1, REG_MOVE_STEP = 2'd2, REG_NONE = 2'd3
  } reg_idx_t;

  localparam logic [8:0] MS_100 = 9'd100;
  localparam logic [8:0] MS_150 = 9'd150;
  localparam logic [8:0] MS_250 = 9'd250;
  localparam logic [8:0] MS_300 = 9'd300;
endpackage

/* sv/cafs_if.sv */
// Valid/ready channel interfaces for the autofocus sequencer.
// Depends on cafs_pkg.
interface cafs_in_if (input logic clk);
  logic valid;
  logic ready;
  logic [cafs_pkg::MEASURE_BITS-1:0] focus_measure;
  modport source (output valid, output focus_measure, input ready);
  modport sink (input valid, input focus_measure, output ready);
endinterface

interface cafs_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [cafs_pkg::POS_BITS-1:0] lens_position;
  logic scan_active;
  logic [8:0] frame_interval_ms;
  logic focus_locked;
  modport source (output valid, output lens_position, output scan_active,
                  output frame_interval_ms, output focus_locked, input ready);
  modport sink (input valid, input lens_position, input scan_active,
                input frame_interval_ms, input focus_locked, output ready);
endinterface

/* sv/contrast_autofocus_scan_fsm.sv */
// Contrast autofocus hill-climb sequencer, top level.
// Depends on cafs_pkg and the cafs_in_if / cafs_out_if interfaces.
//
// Usage: one focus_measure word per camera frame enters on in_ch; one result
// word (lens_position, scan_active, frame_interval_ms, focus_locked) leaves on
// out_ch for every input word. Limits and the transit move step are set over
// the APB port (max_position at 0x0, min_position at 0x4, move_step at 0x8)
// while the block is idle; reads return the current values.
// The result is registered at the edge that accepts the input, so it is
// valid in the next cycle. Throughput: one word per cycle while the receiver
// does not stall; the whole update of the phase machine is one short
// combinational pass between the state registers and the output register.
// Stall: a single output register holds the result; a new word is accepted
// whenever that register is empty or is being drained in the same cycle, so
// a stalled receiver stalls the input after one word.
// Reset (rst, synchronous): phase transit, lens at 280, limits 1023/0, step 20.
module contrast_autofocus_scan_fsm (
  input  logic clk,
  input  logic rst,
  cafs_in_if.sink    in_ch,
  cafs_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [cafs_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int PB = cafs_pkg::POS_BITS;
  localparam int SW = PB + 3;  // signed working width
  localparam int MB = cafs_pkg::MEASURE_BITS;

  // config
  logic [PB-1:0] max_position, min_position;
  logic [7:0] move_step;

  // state
  cafs_pkg::phase_t phase, phase_next;
  logic [PB-1:0] lens_pos, lens_pos_next;
  logic [PB-1:0] transit_target, transit_target_next;
  logic target_is_fine, target_is_fine_next;
  logic [3:0] step_size, step_size_next;
  logic edge_hit, edge_hit_next;
  logic [PB-1:0] window_high, window_high_next, window_low, window_low_next;
  logic [7:0] in_count, in_count_next, in_best_slot, in_best_slot_next;
  logic [MB-1:0] in_best_value, in_best_value_next;
  logic [PB-1:0] in_best_lens, in_best_lens_next;
  logic [7:0] out_count, out_count_next;
  logic [MB-1:0] out_best_value, out_best_value_next;
  logic [PB-1:0] out_best_lens, out_best_lens_next;
  logic [1:0] retry_count, retry_count_next;
  logic drift_inward, drift_inward_next;
  logic scan_flag, scan_flag_next;
  logic [8:0] interval_ms, interval_ms_next;
  logic locked;

  logic accept, out_valid;
  cafs_pkg::reg_idx_t widx;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      2'd0: widx = cafs_pkg::REG_MAX_POS;
      2'd1: widx = cafs_pkg::REG_MIN_POS;
      2'd2: widx = cafs_pkg::REG_MOVE_STEP;
      default: widx = cafs_pkg::REG_NONE;
    endcase
  end

  always_comb begin
    prdata = '0;
    case (widx)
      cafs_pkg::REG_MAX_POS: prdata[PB-1:0] = max_position;
      cafs_pkg::REG_MIN_POS: prdata[PB-1:0] = min_position;
      cafs_pkg::REG_MOVE_STEP: prdata[7:0] = move_step;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_position <= '1;
      min_position <= '0;
      move_step <= 8'd20;
    end else if (psel && penable && pwrite) begin
      case (widx)
        cafs_pkg::REG_MAX_POS: max_position <= pwdata[PB-1:0];
        cafs_pkg::REG_MIN_POS: min_position <= pwdata[PB-1:0];
        cafs_pkg::REG_MOVE_STEP: move_step <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // signed helpers
  logic signed [SW-1:0] smax, smin, slens, swl, sbest, sstep;
  assign smax  = SW'(max_position);
  assign smin  = SW'(min_position);
  assign slens = SW'(lens_pos);
  assign swl   = SW'(window_low);
  assign sbest = SW'(in_best_lens);
  assign sstep = SW'(step_size);

  function automatic logic [PB-1:0] clampw(input logic signed [SW-1:0] v,
                                           input logic signed [SW-1:0] hi,
                                           input logic signed [SW-1:0] lo);
    logic signed [SW-1:0] t;
    t = (v > hi) ? hi : v;
    t = (t < lo) ? lo : t;
    if (t < 0) return '0;
    return t[PB-1:0];
  endfunction

  // clamp lens to 0..POS_MAX
  function automatic logic [PB-1:0] posb(input logic signed [SW-1:0] v);
    if (v < 0) return '0;
    if (v > SW'((1 << PB) - 1)) return '1;
    return v[PB-1:0];
  endfunction

  logic [MB-1:0] meas;
  assign meas = in_ch.focus_measure;

  // running maximum tracker helpers (first max kept)
  logic in_new, out_new;
  logic [7:0] in_cnt_inc, out_cnt_inc, slot_rec;
  assign in_new  = (in_count == 8'd0) || (meas > in_best_value);
  assign out_new = (out_count == 8'd0) || (meas > out_best_value);
  assign in_cnt_inc  = (in_count == 8'hFF) ? in_count : in_count + 8'd1;
  assign out_cnt_inc = (out_count == 8'hFF) ? out_count : out_count + 8'd1;
  // best slot after recording this word
  assign slot_rec = in_new ? in_count : in_best_slot;

  logic signed [SW-1:0] tstp, travel, mag, lp, dn, up;
  logic [7:0] last_slot, slot_gap;
  logic [1:0] rc;
  logic signed [SW-1:0] wh, wlo;
  assign tstp   = (move_step == 8'd0) ? SW'(1) : SW'(move_step);
  assign travel = SW'(transit_target) - slens;
  assign mag    = travel < 0 ? -travel : travel;
  assign dn     = slens - sstep;
  assign up     = slens + sstep;
  assign last_slot = (in_count != 8'd0) ? in_count - 8'd1 : 8'd0;
  assign slot_gap  = in_cnt_inc - slot_rec;

  // next-state
  always_comb begin
    phase_next = phase;
    lp = slens;
    transit_target_next = transit_target;
    target_is_fine_next = target_is_fine;
    step_size_next = step_size;
    edge_hit_next = edge_hit;
    window_high_next = window_high;
    window_low_next = window_low;
    in_count_next = in_count;
    in_best_value_next = in_best_value;
    in_best_slot_next = in_best_slot;
    in_best_lens_next = in_best_lens;
    out_count_next = out_count;
    out_best_value_next = out_best_value;
    out_best_lens_next = out_best_lens;
    retry_count_next = retry_count;
    drift_inward_next = drift_inward;
    scan_flag_next = scan_flag;
    interval_ms_next = interval_ms;
    rc = 2'd0; wh = '0; wlo = '0;

    // trackers record in the scan phases
    if (phase == cafs_pkg::PH_SCAN_IN || phase == cafs_pkg::PH_FINE ||
        phase == cafs_pkg::PH_CONFIRM || phase == cafs_pkg::PH_DRIFT_PEAK) begin
      if (in_new) begin
        in_best_value_next = meas;
        in_best_slot_next = in_count;
        in_best_lens_next = lens_pos;
      end
      in_count_next = in_cnt_inc;
    end
    if (phase == cafs_pkg::PH_SCAN_OUT) begin
      if (out_new) begin
        out_best_value_next = meas;
        out_best_lens_next = lens_pos;
      end
      out_count_next = out_cnt_inc;
    end

    case (phase)
      cafs_pkg::PH_TRANSIT: begin
        scan_flag_next = 1'b0; interval_ms_next = cafs_pkg::MS_250;
        if (mag > tstp) begin
          lp = travel > 0 ? slens + tstp : slens - tstp;
        end else begin
          lp = SW'(transit_target);
          phase_next = target_is_fine ? cafs_pkg::PH_START_FINE : cafs_pkg::PH_START_IN;
        end
      end
      cafs_pkg::PH_START_IN: begin
        in_count_next = '0; in_best_value_next = '0; in_best_slot_next = '0;
        in_best_lens_next = '0;
        step_size_next = 4'd10; lp = smax; edge_hit_next = 1'b0;
        scan_flag_next = 1'b1; interval_ms_next = cafs_pkg::MS_100;
        phase_next = cafs_pkg::PH_SCAN_IN;
      end
      cafs_pkg::PH_SCAN_IN: begin
        if (!edge_hit) lp = dn;
        else begin
          phase_next = cafs_pkg::PH_START_OUT; lp = smin;
        end
        if (lp <= smin) begin
          edge_hit_next = 1'b1; lp = smin;
        end
      end
      cafs_pkg::PH_START_OUT: begin
        out_count_next = '0; out_best_value_next = '0; out_best_lens_next = '0;
        step_size_next = 4'd10; lp = smin; edge_hit_next = 1'b0;
        scan_flag_next = 1'b1; interval_ms_next = cafs_pkg::MS_100;
        phase_next = cafs_pkg::PH_SCAN_OUT;
      end
      cafs_pkg::PH_SCAN_OUT: begin
        if (!edge_hit) lp = up;
        else begin
          window_high_next = clampw(sbest + SW'(10), smax, smin);
          window_low_next = clampw(SW'(out_best_lens) - SW'(10), smax, smin);
          transit_target_next = window_high_next;
          target_is_fine_next = 1'b1;
          phase_next = cafs_pkg::PH_TRANSIT;
          lp = smax;
        end
        if (lp >= smax) begin
          edge_hit_next = 1'b1; lp = smax;
        end
      end
      cafs_pkg::PH_START_FINE: begin
        in_count_next = '0; in_best_value_next = '0; in_best_slot_next = '0;
        in_best_lens_next = '0;
        out_count_next = '0; out_best_value_next = '0; out_best_lens_next = '0;
        step_size_next = 4'd2; lp = SW'(window_high); edge_hit_next = 1'b0;
        scan_flag_next = 1'b1; interval_ms_next = cafs_pkg::MS_150;
        phase_next = cafs_pkg::PH_FINE;
      end
      cafs_pkg::PH_FINE: begin
        if (!edge_hit) lp = dn;
        else begin
          phase_next = cafs_pkg::PH_SET_FOCUS; lp = swl;
        end
        if (lp <= swl) begin
          edge_hit_next = 1'b1; lp = swl;
        end
      end
      cafs_pkg::PH_SET_FOCUS: begin
        if (in_best_slot == 8'd0 || in_best_slot == last_slot) begin
          rc = retry_count + 2'd1;
          if (in_best_slot == 8'd0) begin
            wh = sbest + SW'(40); wlo = sbest;
          end else begin
            wh = sbest; wlo = sbest - SW'(40);
          end
        end else begin
          rc = 2'd0; wh = sbest + SW'(20); wlo = sbest - SW'(20);
        end
        window_high_next = clampw(wh, smax, smin);
        window_low_next = clampw(wlo, smax, smin);
        lp = sbest;
        retry_count_next = rc;
        if (rc == 2'd0) begin
          scan_flag_next = 1'b1; interval_ms_next = cafs_pkg::MS_300;
          phase_next = cafs_pkg::PH_LOCK;
        end else if (rc > 2'd2) begin
          retry_count_next = 2'd0;
          target_is_fine_next = 1'b0; transit_target_next = max_position;
          phase_next = cafs_pkg::PH_TRANSIT;
        end else begin
          phase_next = cafs_pkg::PH_START_FINE;
        end
      end
      cafs_pkg::PH_LOCK: begin
        scan_flag_next = 1'b0; interval_ms_next = cafs_pkg::MS_250;
        phase_next = cafs_pkg::PH_START_DRIFT;
      end
      cafs_pkg::PH_START_DRIFT: begin
        in_count_next = '0; in_best_value_next = '0; in_best_slot_next = '0;
        in_best_lens_next = '0;
        out_count_next = '0; out_best_value_next = '0; out_best_lens_next = '0;
        step_size_next = 4'd5; edge_hit_next = 1'b0; drift_inward_next = 1'b1;
        scan_flag_next = 1'b1; interval_ms_next = cafs_pkg::MS_150;
        phase_next = cafs_pkg::PH_CONFIRM;
      end
      cafs_pkg::PH_CONFIRM: begin
        if (in_cnt_inc >= 8'd5) begin
          if (slot_rec <= 8'd2) begin
            drift_inward_next = 1'b0;
            in_count_next = '0; in_best_value_next = '0; in_best_slot_next = '0;
            in_best_lens_next = '0;
          end
          phase_next = cafs_pkg::PH_DRIFT_PEAK;
        end
        lp = dn;
        if (lp < smin) begin
          lp = smin;
          target_is_fine_next = 1'b0; transit_target_next = max_position;
          phase_next = cafs_pkg::PH_TRANSIT;
        end
      end
      default: begin
        if (slot_gap < 8'd5) begin
          if (drift_inward) begin
            lp = dn;
            if (lp < smin) begin
              edge_hit_next = 1'b1; lp = smin;
            end
          end else begin
            lp = up;
            if (lp > smax) begin
              edge_hit_next = 1'b1; lp = smax;
            end
          end
          if (in_cnt_inc > 8'd50 || edge_hit_next) begin
            target_is_fine_next = 1'b0; transit_target_next = max_position;
            phase_next = cafs_pkg::PH_TRANSIT;
          end
        end else begin
          lp = SW'(in_best_lens_next);
          scan_flag_next = 1'b1; interval_ms_next = cafs_pkg::MS_300;
          phase_next = cafs_pkg::PH_LOCK;
        end
      end
    endcase
    lens_pos_next = posb(lp);
  end

  // outputs of the phase machine
  always_comb begin
    case (phase)
      cafs_pkg::PH_LOCK: locked = 1'b1;
      default: locked = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cafs_pkg::PH_TRANSIT;
      lens_pos <= PB'(280);
      transit_target <= '1;
      target_is_fine <= 1'b0;
      step_size <= 4'd10;
      edge_hit <= 1'b0;
      window_high <= '0;
      window_low <= '0;
      in_count <= '0;
      in_best_value <= '0;
      in_best_slot <= '0;
      in_best_lens <= '0;
      out_count <= '0;
      out_best_value <= '0;
      out_best_lens <= '0;
      retry_count <= '0;
      drift_inward <= 1'b1;
      scan_flag <= 1'b0;
      interval_ms <= cafs_pkg::MS_250;
    end else if (accept) begin
      phase <= phase_next;
      lens_pos <= lens_pos_next;
      transit_target <= transit_target_next;
      target_is_fine <= target_is_fine_next;
      step_size <= step_size_next;
      edge_hit <= edge_hit_next;
      window_high <= window_high_next;
      window_low <= window_low_next;
      in_count <= in_count_next;
      in_best_value <= in_best_value_next;
      in_best_slot <= in_best_slot_next;
      in_best_lens <= in_best_lens_next;
      out_count <= out_count_next;
      out_best_value <= out_best_value_next;
      out_best_lens <= out_best_lens_next;
      retry_count <= retry_count_next;
      drift_inward <= drift_inward_next;
      scan_flag <= scan_flag_next;
      interval_ms <= interval_ms_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (accept) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.lens_position <= lens_pos_next;
      out_ch.scan_active <= scan_flag_next;
      out_ch.frame_interval_ms <= interval_ms_next;
      out_ch.focus_locked <= locked;
    end
  end
  assign out_ch.valid = out_valid;

  // checks
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_ch.lens_position))
    else $error("result changed while stalled");
  a_lock_pulse: assert property (@(posedge clk) disable iff (rst)
    accept && phase == cafs_pkg::PH_LOCK |=> phase == cafs_pkg::PH_START_DRIFT)
    else $error("lock not followed by drift start");
  a_lock_flags: assert property (@(posedge clk) disable iff (rst)
    accept && locked |=> !out_ch.scan_active && out_ch.frame_interval_ms == cafs_pkg::MS_250)
    else $error("locked result has wrong flags");
  a_no_accept_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !in_ch.ready)
    else $error("accepted while result stalled");
endmodule

/* tb/tb_cafs_if.sv */
// Testbench copy note: the channel interfaces live in the RTL (sv/cafs_if.sv);
// this file holds only the APB drive helper bundle used by the testbench top.
`timescale 1ns / 1ps
interface tb_cafs_apb_if (input logic clk);
  logic psel;
  logic penable;
  logic pwrite;
  logic [cafs_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
endinterface

/* tb/tb_contrast_autofocus_scan_fsm.sv */
// Self-checking testbench for contrast_autofocus_scan_fsm.
// Depends on cafs_pkg, cafs_in_if/cafs_out_if and tb_cafs_apb_if; drives random
// focus measures through several limit settings and checks every result word.
`timescale 1ns / 1ps
module tb_contrast_autofocus_scan_fsm;
  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cafs_in_if  in_ch (clk);
  cafs_out_if out_ch (clk);
  tb_cafs_apb_if apb (clk);

  contrast_autofocus_scan_fsm dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite), .paddr(apb.paddr),
    .pwdata(apb.pwdata), .prdata(apb.prdata), .pready(apb.pready)
  );

  typedef struct packed {
    logic [cafs_pkg::POS_BITS-1:0] lens;
    logic scan;
    logic [8:0] interval;
    logic locked;
  } af_result_t;

  // ---------------------------------------------------------------------------
  // Focus predictor: own copy of limits and phase machine state.
  // Positions are kept as int so negative overshoot clamps like the block's.
  // ---------------------------------------------------------------------------
  int lim_hi, lim_lo, tstep;
  cafs_pkg::phase_t ph;
  int lens, target, win_hi, win_lo, stride;
  bit to_fine, at_edge, inward, scanning;
  int unsigned n_in, best_in, best_slot, best_in_lens;
  int unsigned n_out, best_out, best_out_lens;
  int unsigned retries, ms;
  af_result_t results_due[$];
  logic [31:0] measures_pending[$];

  localparam int POS_TOP = (1 << cafs_pkg::POS_BITS) - 1;

  function automatic int clip_win(int v);
    if (v > lim_hi) v = lim_hi;
    if (v < lim_lo) v = lim_lo;
    return v;
  endfunction

  function automatic int unsigned to_pos(int p);
    if (p < 0) return 0;
    if (p > POS_TOP) return POS_TOP;
    return p;
  endfunction

  task automatic take_in(int unsigned v);
    if (n_in == 0 || v > best_in) begin
      best_in = v; best_slot = n_in; best_in_lens = to_pos(lens);
    end
    if (n_in < 255) n_in++;
  endtask

  task automatic take_out(int unsigned v);
    if (n_out == 0 || v > best_out) begin
      best_out = v; best_out_lens = to_pos(lens);
    end
    if (n_out < 255) n_out++;
  endtask

  task automatic wipe_in();
    n_in = 0; best_in = 0; best_slot = 0; best_in_lens = 0;
  endtask

  task automatic wipe_out();
    n_out = 0; best_out = 0; best_out_lens = 0;
  endtask

  task automatic restart_scan();
    to_fine = 0; target = lim_hi; ph = cafs_pkg::PH_TRANSIT;
  endtask

  task automatic focus_reset();
    lim_hi = POS_TOP; lim_lo = 0; tstep = 20;
    ph = cafs_pkg::PH_TRANSIT; lens = 280; target = lim_hi; to_fine = 0; stride = 10;
    at_edge = 0; win_hi = 0; win_lo = 0; wipe_in(); wipe_out();
    retries = 0; inward = 1; scanning = 0; ms = 250;
  endtask

  task automatic predict_focus(logic [31:0] v);
    af_result_t r;
    int stp, travel, mag, best;
    int unsigned last;
    bit lock_now;
    lock_now = 0;
    case (ph)
      cafs_pkg::PH_TRANSIT: begin
        stp = (tstep == 0) ? 1 : tstep;
        travel = target - lens;
        mag = travel < 0 ? -travel : travel;
        scanning = 0; ms = 250;
        if (mag > stp) lens += (travel > 0) ? stp : -stp;
        else begin
          lens = target;
          ph = to_fine ? cafs_pkg::PH_START_FINE : cafs_pkg::PH_START_IN;
        end
      end
      cafs_pkg::PH_START_IN: begin
        wipe_in(); stride = 10; lens = lim_hi; at_edge = 0;
        scanning = 1; ms = 100; ph = cafs_pkg::PH_SCAN_IN;
      end
      cafs_pkg::PH_SCAN_IN: begin
        take_in(v);
        if (!at_edge) lens -= stride;
        else begin ph = cafs_pkg::PH_START_OUT; lens = lim_lo; end
        if (lens <= lim_lo) begin at_edge = 1; lens = lim_lo; end
      end
      cafs_pkg::PH_START_OUT: begin
        wipe_out(); stride = 10; lens = lim_lo; at_edge = 0;
        scanning = 1; ms = 100; ph = cafs_pkg::PH_SCAN_OUT;
      end
      cafs_pkg::PH_SCAN_OUT: begin
        take_out(v);
        if (!at_edge) lens += stride;
        else begin
          win_hi = clip_win(int'(best_in_lens) + 10);
          win_lo = clip_win(int'(best_out_lens) - 10);
          target = win_hi; to_fine = 1; ph = cafs_pkg::PH_TRANSIT; lens = lim_hi;
        end
        if (lens >= lim_hi) begin at_edge = 1; lens = lim_hi; end
      end
      cafs_pkg::PH_START_FINE: begin
        wipe_in(); wipe_out(); stride = 2; lens = win_hi; at_edge = 0;
        scanning = 1; ms = 150; ph = cafs_pkg::PH_FINE;
      end
      cafs_pkg::PH_FINE: begin
        take_in(v);
        if (!at_edge) lens -= stride;
        else begin ph = cafs_pkg::PH_SET_FOCUS; lens = win_lo; end
        if (lens <= win_lo) begin at_edge = 1; lens = win_lo; end
      end
      cafs_pkg::PH_SET_FOCUS: begin
        best = best_in_lens;
        last = n_in ? n_in - 1 : 0;
        if (best_slot == 0 || best_slot == last) begin
          retries = (retries + 1) & 3;
          if (best_slot == 0) begin win_hi = best + 40; win_lo = best; end
          else begin win_hi = best; win_lo = best - 40; end
        end else begin
          retries = 0; win_hi = best + 20; win_lo = best - 20;
        end
        win_hi = clip_win(win_hi);
        win_lo = clip_win(win_lo);
        lens = best;
        if (retries == 0) begin scanning = 1; ms = 300; ph = cafs_pkg::PH_LOCK; end
        else if (retries > 2) begin retries = 0; restart_scan(); end
        else ph = cafs_pkg::PH_START_FINE;
      end
      cafs_pkg::PH_LOCK: begin
        lock_now = 1; scanning = 0; ms = 250; ph = cafs_pkg::PH_START_DRIFT;
      end
      cafs_pkg::PH_START_DRIFT: begin
        wipe_in(); wipe_out(); stride = 5; at_edge = 0; inward = 1;
        scanning = 1; ms = 150; ph = cafs_pkg::PH_CONFIRM;
      end
      cafs_pkg::PH_CONFIRM: begin
        take_in(v);
        if (n_in >= 5) begin
          if (best_slot <= 2) begin inward = 0; wipe_in(); end
          ph = cafs_pkg::PH_DRIFT_PEAK;
        end
        lens -= stride;
        if (lens < lim_lo) begin lens = lim_lo; restart_scan(); end
      end
      default: begin
        take_in(v);
        if (n_in - best_slot < 5) begin
          if (inward) begin
            lens -= stride;
            if (lens < lim_lo) begin at_edge = 1; lens = lim_lo; end
          end else begin
            lens += stride;
            if (lens > lim_hi) begin at_edge = 1; lens = lim_hi; end
          end
          if (n_in > 50 || at_edge) restart_scan();
        end else begin
          lens = best_in_lens; scanning = 1; ms = 300; ph = cafs_pkg::PH_LOCK;
        end
      end
    endcase
    lens = to_pos(lens);
    r.lens = lens[cafs_pkg::POS_BITS-1:0];
    r.scan = scanning;
    r.interval = ms[8:0];
    r.locked = lock_now;
    results_due.insert(results_due.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // Idle control: 0 none, 1 sender gaps, 2 receiver stalls, 3 both light.
  // ---------------------------------------------------------------------------
  int idle_mode = 0;
  int errors = 0;
  int sent = 0;

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // driver: pops pending measures, idles per mode
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.focus_measure <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) sent <= sent + 1;
      if (measures_pending.size() != 0 &&
          !((idle_mode == 1 && chance(81)) || (idle_mode == 3 && chance(7)))) begin
        in_ch.valid <= 1'b1;
        in_ch.focus_measure <= measures_pending.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predictor hooks the accepted word at the same edge
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) predict_focus(in_ch.focus_measure);
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !((idle_mode == 2 && chance(81)) || (idle_mode == 3 && chance(7)));
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    af_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) report_mismatch("unexpected word", 1, 0);
      else begin
        want = results_due.pop_front();
        if (out_ch.lens_position !== want.lens)
          report_mismatch("lens_position", out_ch.lens_position, want.lens);
        if (out_ch.scan_active !== want.scan)
          report_mismatch("scan_active", out_ch.scan_active, want.scan);
        if (out_ch.frame_interval_ms !== want.interval)
          report_mismatch("frame_interval_ms", out_ch.frame_interval_ms, want.interval);
        if (out_ch.focus_locked !== want.locked)
          report_mismatch("focus_locked", out_ch.focus_locked, want.locked);
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // APB write: setup then access; predictor updated at the write edge
  task automatic reg_write(cafs_pkg::reg_idx_t idx, int unsigned value);
    @(posedge clk);
    apb.psel <= 1'b1; apb.penable <= 1'b0; apb.pwrite <= 1'b1;
    apb.paddr <= cafs_pkg::CFG_ADDR_BITS'(4 * idx); apb.pwdata <= value;
    @(posedge clk);
    apb.penable <= 1'b1;
    @(posedge clk);
    apb.psel <= 1'b0; apb.penable <= 1'b0; apb.pwrite <= 1'b0;
    case (idx)
      cafs_pkg::REG_MAX_POS: lim_hi = value & POS_TOP;
      cafs_pkg::REG_MIN_POS: lim_lo = value & POS_TOP;
      cafs_pkg::REG_MOVE_STEP: tstep = value & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (measures_pending.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Measures mostly form a smooth hill so scans find inner peaks and lock;
  // some are raw noise with all 32 bits random.
  task automatic queue_frames(int count, int peak);
    int unsigned m;
    for (int k = 0; k < count; k++) begin
      if (chance(25)) m = $urandom;
      else begin
        m = 32'd2_000_000 - 1000 * ((k * 7 + peak) % 41 - 20) ** 2;
        if (chance(30)) m ^= $urandom_range(255);
      end
      measures_pending.insert(measures_pending.size(), m);
    end
  endtask

  initial begin
    apb.psel = 1'b0; apb.penable = 1'b0; apb.pwrite = 1'b0;
    apb.paddr = '0; apb.pwdata = '0;
    in_ch.valid = 1'b0; in_ch.focus_measure = '0; out_ch.ready = 1'b0;
    focus_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of the measure, equal values, all-ones and zero
    measures_pending.insert(measures_pending.size(), 32'h0);
    measures_pending.insert(measures_pending.size(), 32'hFFFF_FFFF);
    measures_pending.insert(measures_pending.size(), 32'hFFFF_FFFF);
    measures_pending.insert(measures_pending.size(), 32'h8000_0000);
    measures_pending.insert(measures_pending.size(), 32'h0000_0001);
    drain();

    // small window, zero transit step (acts as one), short scans
    reg_write(cafs_pkg::REG_MAX_POS, 120);
    reg_write(cafs_pkg::REG_MIN_POS, 60);
    reg_write(cafs_pkg::REG_MOVE_STEP, 0);
    idle_mode = 0;
    for (int k = 0; k < 20; k++)
      measures_pending.insert(measures_pending.size(), k < 10 ? k : 32'hFFFF_FFFF - k);
    queue_frames(180, 3);
    drain();

    // inverted limits, then tight window at the top
    reg_write(cafs_pkg::REG_MIN_POS, 200);
    reg_write(cafs_pkg::REG_MAX_POS, 150);
    reg_write(cafs_pkg::REG_MOVE_STEP, 255);
    idle_mode = 1;
    queue_frames(100, 11);
    drain();

    reg_write(cafs_pkg::REG_MAX_POS, 1023);
    reg_write(cafs_pkg::REG_MIN_POS, 980);
    reg_write(cafs_pkg::REG_MOVE_STEP, 1);
    idle_mode = 2;
    queue_frames(200, 17);
    drain();

    // bottom of range with step size overshooting below zero
    reg_write(cafs_pkg::REG_MAX_POS, 45);
    reg_write(cafs_pkg::REG_MIN_POS, 0);
    reg_write(cafs_pkg::REG_MOVE_STEP, 7);
    idle_mode = 3;
    queue_frames(200, 29);
    drain();

    // wide limits 400/100, random step
    reg_write(cafs_pkg::REG_MAX_POS, 400);
    reg_write(cafs_pkg::REG_MIN_POS, 100);
    reg_write(cafs_pkg::REG_MOVE_STEP, $urandom_range(1, 255));
    idle_mode = 0;
    queue_frames(250, 5);
    drain();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
